>>> sv/tsw_pkg.sv
// ---------------------------------------------------------------------------
// tsw_pkg: shared types and codes of the TCP sender engine
// Action and result kind codes, result beat record and its builder.
// ---------------------------------------------------------------------------
package tsw_pkg;

	// input actions
	localparam logic [2:0] ACT_WRITE = 3'd0;
	localparam logic [2:0] ACT_FILL  = 3'd1;
	localparam logic [2:0] ACT_ACK   = 3'd2;
	localparam logic [2:0] ACT_TICK  = 3'd3;
	localparam logic [2:0] ACT_EMPTY = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_NEW    = 2'd0;
	localparam logic [1:0] KIND_RETX   = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// register indexes
	localparam logic [1:0] REG_ISN     = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_CAP     = 2'd2;

	localparam logic [31:0] ISN_RST     = 32'd0;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;
	localparam logic [15:0] CAP_RST     = 16'd65535;
	localparam int          MAX_RES     = 32;
	localparam int          LEN_CAP     = 1023;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq_wrapped;
		logic [63:0] abs_position;
		logic [9:0]  payload_length;
		logic        syn_flag;
		logic        fin_flag;
		logic [15:0] in_flight;
		logic [7:0]  retx_streak;
		logic [15:0] accepted_count;
		logic        last;
	} result_t;

	// build one result beat; segment fields are zero on a write status
	function automatic result_t make_result(input logic [1:0] kind, input logic [63:0] abs,
			input logic [11:0] lf, input logic [31:0] isn, input logic [15:0] flight,
			input logic [7:0] retx, input logic [15:0] acc);
		result_t r;
		logic seg;
		seg = (kind != KIND_STATUS);
		r.kind           = kind;
		r.seq_wrapped    = seg ? abs[31:0] + isn : 32'd0;
		r.abs_position   = seg ? abs : 64'd0;
		r.payload_length = seg ? lf[9:0] : 10'd0;
		r.syn_flag       = seg ? lf[10] : 1'b0;
		r.fin_flag       = seg ? lf[11] : 1'b0;
		r.in_flight      = flight;
		r.retx_streak    = retx;
		r.accepted_count = seg ? 16'd0 : acc;
		r.last           = 1'b0;
		return r;
	endfunction

	// mark a beat as the final one of its command
	function automatic result_t with_last(input result_t r);
		result_t o;
		o      = r;
		o.last = 1'b1;
		return o;
	endfunction

endpackage

>>> sv/tsw_ram.sv
// ---------------------------------------------------------------------------
// tsw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module tsw_ram #(
	parameter int WIDTH = 76,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> sv/tcp_sender_window_retransmit.sv
// Write status and empty segment: result one cycle after start, busy stays low.
// Fill: 1 cycle per segment, 1 more to find the window shut (none after a FIN), 1 to flush.
// Ack: 1 cycle to unwrap (a dropped ack ends there), 2 per freed descriptor, then 2 with
// the queue empty or 3 otherwise, then a fill. Tick: 1 cycle, or 2 with a retransmission.
// Results are never held off. Reset (arst_n low) clears all control state; RAM is not cleared.
// ---------------------------------------------------------------------------
// tcp_sender_window_retransmit: TCP sender control engine
// Send buffer accounting, window fill into a descriptor FIFO, ack handling
// and retransmission timer, sequenced over a shared step datapath.
// ---------------------------------------------------------------------------
module tcp_sender_window_retransmit #(
	parameter int MAX_PAYLOAD = 1000,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [15:0] write_count,
	input  logic        write_end,
	input  logic [31:0] ack_number,
	input  logic [15:0] window_bytes,
	input  logic [15:0] elapsed_ms,
	// results
	output logic        result_valid,
	output logic [1:0]  kind,
	output logic [31:0] seq_wrapped,
	output logic [63:0] abs_position,
	output logic [9:0]  payload_length,
	output logic        syn_flag,
	output logic        fin_flag,
	output logic [15:0] in_flight,
	output logic [7:0]  retx_streak,
	output logic [15:0] accepted_count,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tsw_pkg::*;

	localparam int IW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int MAXP = (MAX_PAYLOAD < LEN_CAP) ? MAX_PAYLOAD : LEN_CAP;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_FILL      = 4'd1;
	localparam logic [3:0] ST_FLUSH     = 4'd2;
	localparam logic [3:0] ST_ACK_UNW   = 4'd3;
	localparam logic [3:0] ST_ACK_RD    = 4'd4;
	localparam logic [3:0] ST_ACK_CHK   = 4'd5;
	localparam logic [3:0] ST_ACK_FIN   = 4'd6;
	localparam logic [3:0] ST_TICK      = 4'd7;
	localparam logic [3:0] ST_TICK_EMIT = 4'd8;

	// configuration registers
	logic [31:0] isn_q;
	logic [15:0] init_to_q;
	logic [15:0] cap_q;

	// engine state
	logic [3:0]    state_q;
	logic [15:0]   buffered_q;
	logic          closed_q;
	logic [63:0]   np_q;
	logic          syn_sent_q;
	logic          fin_sent_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [15:0]   flight_q;
	logic [31:0]   timer_q;
	logic [31:0]   timeout_q;
	logic [7:0]    retx_q;
	logic [15:0]   peer_q;
	logic [5:0]    nres_q;

	// latched command fields
	logic [31:0] ack_q;
	logic [15:0] win_in_q;
	logic [15:0] elapsed_q;
	logic [63:0] abs_ack_q;

	// pending and output beats
	result_t pend_q;
	logic    pend_vld_q;
	result_t out_q;
	logic    out_vld_q;

	// descriptor RAM
	logic          ram_we;
	logic [75:0]   ram_wdata;
	logic [75:0]   ram_rdata;
	logic [63:0]   rd_start;
	logic [11:0]   rd_lf;

	tsw_ram #(.WIDTH(76), .DEPTH(QUEUE_DEPTH)) u_desc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.raddr (head_q),
		.rdata (ram_rdata)
	);
	assign rd_start = ram_rdata[75:12];
	assign rd_lf    = ram_rdata[11:0];

	// APB port
	logic       cfg_wr;
	logic [1:0] cfg_idx;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		unique case (cfg_idx)
			REG_ISN:     prdata = isn_q;
			REG_TIMEOUT: prdata = {16'd0, init_to_q};
			REG_CAP:     prdata = {16'd0, cap_q};
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isn_q     <= ISN_RST;
			init_to_q <= TIMEOUT_RST;
			cap_q     <= CAP_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ISN:     isn_q <= pwdata;
				REG_TIMEOUT: init_to_q <= pwdata[15:0];
				REG_CAP:     cap_q <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	// write step: accepted bytes
	logic [15:0] free_sp;
	logic [15:0] acc;
	always_comb begin
		free_sp = (cap_q > buffered_q) ? cap_q - buffered_q : 16'd0;
		acc     = closed_q ? 16'd0 : ((write_count < free_sp) ? write_count : free_sp);
	end

	// fill step: one segment per cycle
	logic [15:0] win;
	logic [15:0] room;
	logic        synb;
	logic [15:0] pay_w;
	logic        fin_c;
	logic [10:0] seg_len;
	logic        fill_go;
	logic [16:0] fl_sum;
	logic [15:0] flight_new;
	logic [64:0] np_sum;
	logic [63:0] np_new;
	logic [11:0] new_lf;
	always_comb begin
		win   = (peer_q == 16'd0) ? 16'd1 : peer_q;
		room  = win - flight_q;
		synb  = !syn_sent_q;
		pay_w = (room > {15'd0, synb}) ? room - {15'd0, synb} : 16'd0;
		if (pay_w > 16'(MAXP)) begin
			pay_w = 16'(MAXP);
		end
		if (pay_w > buffered_q) begin
			pay_w = buffered_q;
		end
		fin_c = !fin_sent_q && closed_q && (buffered_q == pay_w)
			&& (({1'b0, pay_w} + {16'd0, synb}) < {1'b0, room});
		seg_len = pay_w[10:0] + {10'd0, synb} + {10'd0, fin_c};
		fill_go = (win > flight_q) && (count_q < CW'(QUEUE_DEPTH))
			&& (nres_q < 6'(MAX_RES)) && (seg_len != 11'd0);
		fl_sum     = {1'b0, flight_q} + {6'd0, seg_len};
		flight_new = fl_sum[16] ? 16'hFFFF : fl_sum[15:0];
		np_sum     = {1'b0, np_q} + {54'd0, seg_len};
		np_new     = np_sum[64] ? {64{1'b1}} : np_sum[63:0];
		new_lf     = {fin_c, synb, pay_w[9:0]};
	end
	assign ram_we    = (state_q == ST_FILL) && fill_go;
	assign ram_wdata = {np_q, new_lf};

	// ack unwrap to the absolute position nearest next_position
	logic [31:0] off;
	logic [63:0] abs_c;
	always_comb begin
		off   = ack_q - isn_q;
		abs_c = {np_q[63:32], off};
		if (off > np_q[31:0]) begin
			if ((off - np_q[31:0]) > 32'h8000_0000 && np_q[63:32] != 32'd0) begin
				abs_c = {np_q[63:32] - 32'd1, off};
			end
		end else if (off < np_q[31:0]) begin
			if ((np_q[31:0] - off) > 32'h8000_0000 && np_q[63:32] != 32'hFFFF_FFFF) begin
				abs_c = {np_q[63:32] + 32'd1, off};
			end
		end
	end

	// ack pop check on the head descriptor
	logic [10:0] hd_len;
	logic [64:0] hd_end;
	logic        hd_covered;
	always_comb begin
		hd_len     = {1'b0, rd_lf[9:0]} + {10'd0, rd_lf[10]} + {10'd0, rd_lf[11]};
		hd_end     = {1'b0, rd_start} + {54'd0, hd_len};
		hd_covered = (hd_end <= {1'b0, abs_ack_q});
	end

	// tick: saturating timer
	logic [32:0] t_sum;
	logic [31:0] timer_new;
	assign t_sum     = {1'b0, timer_q} + {17'd0, elapsed_q};
	assign timer_new = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			buffered_q <= 16'd0;
			closed_q   <= 1'b0;
			np_q       <= 64'd0;
			syn_sent_q <= 1'b0;
			fin_sent_q <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			flight_q   <= 16'd0;
			timer_q    <= 32'd0;
			timeout_q  <= {16'd0, TIMEOUT_RST};
			retx_q     <= 8'd0;
			peer_q     <= 16'd1;
			nres_q     <= 6'd0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						ack_q     <= ack_number;
						win_in_q  <= window_bytes;
						elapsed_q <= elapsed_ms;
						nres_q    <= 6'd0;
						unique case (action)
							ACT_WRITE: begin
								buffered_q <= buffered_q + acc;
								if (write_end) begin
									closed_q <= 1'b1;
								end
								out_q <= with_last(make_result(KIND_STATUS, 64'd0, 12'd0,
									isn_q, flight_q, retx_q, acc));
								out_vld_q <= 1'b1;
							end
							ACT_EMPTY: begin
								out_q <= with_last(make_result(KIND_EMPTY, np_q, 12'd0,
									isn_q, flight_q, retx_q, 16'd0));
								out_vld_q <= 1'b1;
							end
							ACT_FILL: state_q <= ST_FILL;
							ACT_ACK:  state_q <= ST_ACK_UNW;
							ACT_TICK: state_q <= ST_TICK;
							default:  ;
						endcase
					end
				end
				ST_FILL: begin
					if (!fill_go) begin
						state_q <= ST_FLUSH;
					end else begin
						syn_sent_q <= 1'b1;
						if (fin_c) begin
							fin_sent_q <= 1'b1;
							state_q    <= ST_FLUSH;
						end
						buffered_q <= buffered_q - pay_w;
						if (count_q == '0) begin
							timeout_q <= {16'd0, init_to_q};
							timer_q   <= 32'd0;
						end
						tail_q   <= (tail_q == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
						count_q  <= count_q + 1'b1;
						flight_q <= flight_new;
						np_q     <= np_new;
						nres_q   <= nres_q + 6'd1;
						if (pend_vld_q) begin
							out_q     <= pend_q;
							out_vld_q <= 1'b1;
						end
						pend_q     <= make_result(KIND_NEW, np_q, new_lf, isn_q,
							flight_new, retx_q, 16'd0);
						pend_vld_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (pend_vld_q) begin
						out_q     <= with_last(pend_q);
						out_vld_q <= 1'b1;
					end
					pend_vld_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				ST_ACK_UNW: begin
					abs_ack_q <= abs_c;
					state_q   <= (abs_c > np_q) ? ST_IDLE : ST_ACK_RD;
				end
				ST_ACK_RD: begin
					state_q <= (count_q == '0) ? ST_ACK_FIN : ST_ACK_CHK;
				end
				ST_ACK_CHK: begin
					if (hd_covered) begin
						flight_q  <= (flight_q > {5'd0, hd_len}) ? flight_q - {5'd0, hd_len}
							: 16'd0;
						head_q    <= (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_q   <= count_q - 1'b1;
						timeout_q <= {16'd0, init_to_q};
						timer_q   <= 32'd0;
						state_q   <= ST_ACK_RD;
					end else begin
						state_q <= ST_ACK_FIN;
					end
				end
				ST_ACK_FIN: begin
					retx_q  <= 8'd0;
					peer_q  <= win_in_q;
					state_q <= ST_FILL;
				end
				ST_TICK: begin
					if (count_q != '0 && timer_new >= timeout_q) begin
						if (peer_q != 16'd0) begin
							timeout_q <= timeout_q[31] ? 32'hFFFF_FFFF : {timeout_q[30:0], 1'b0};
						end
						timer_q <= 32'd0;
						if (retx_q != 8'hFF) begin
							retx_q <= retx_q + 8'd1;
						end
						state_q <= ST_TICK_EMIT;
					end else begin
						timer_q <= timer_new;
						state_q <= ST_IDLE;
					end
				end
				ST_TICK_EMIT: begin
					out_q     <= with_last(make_result(KIND_RETX, rd_start, rd_lf, isn_q,
						flight_q, retx_q, 16'd0));
					out_vld_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ports
	assign busy           = (state_q != ST_IDLE);
	assign result_valid   = out_vld_q;
	assign kind           = out_q.kind;
	assign seq_wrapped    = out_q.seq_wrapped;
	assign abs_position   = out_q.abs_position;
	assign payload_length = out_q.payload_length;
	assign syn_flag       = out_q.syn_flag;
	assign fin_flag       = out_q.fin_flag;
	assign in_flight      = out_q.in_flight;
	assign retx_streak    = out_q.retx_streak;
	assign accepted_count = out_q.accepted_count;
	assign last           = out_q.last;
endmodule

>>> sv/tsw_checker.sv
// ---------------------------------------------------------------------------
// tsw_checker: port-level checks of the TCP sender engine
// Result beat contents and command-to-result timing.
// ---------------------------------------------------------------------------
module tsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  action,
	input logic        result_valid,
	input logic [1:0]  kind,
	input logic [9:0]  payload_length,
	input logic        syn_flag,
	input logic        fin_flag,
	input logic [15:0] accepted_count,
	input logic        last
);
	import tsw_pkg::*;

	// a write beat comes back as a final status next cycle
	a_write_status: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_WRITE) |=> (result_valid && last && kind == KIND_STATUS))
		else $error("write did not produce a status beat");

	// unknown actions produce nothing
	a_unknown_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action > ACT_EMPTY) |=> !result_valid)
		else $error("unknown action produced a result");

	// segments never report accepted bytes
	a_seg_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind != KIND_STATUS) |-> (accepted_count == 16'd0))
		else $error("segment beat carries accepted count");

	// status beats carry no segment content
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_STATUS) |-> (payload_length == 10'd0 && !syn_flag
			&& !fin_flag))
		else $error("status beat carries segment fields");
endmodule

bind tcp_sender_window_retransmit tsw_checker u_tsw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.action         (action),
	.result_valid   (result_valid),
	.kind           (kind),
	.payload_length (payload_length),
	.syn_flag       (syn_flag),
	.fin_flag       (fin_flag),
	.accepted_count (accepted_count),
	.last           (last)
);
